@@ hw/rtl/delivery_rate_estimator_defines.svh @@
// assertion macros shared by the delivery rate estimator checker
// expects signals named clock and reset in the module that uses them
`ifndef DELIVERY_RATE_ESTIMATOR_DEFINES_SVH
`define DELIVERY_RATE_ESTIMATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define DRE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("delivery rate estimator check failed");

// next-cycle implication, off during reset
`define DRE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("delivery rate estimator check failed");

// next-cycle implication that also holds across reset
`define DRE_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("delivery rate estimator check failed");

`endif

@@ hw/rtl/drest_pkg.sv @@
// shared types and constants for the delivery rate estimator
// no dependencies
package drest_pkg;

   localparam int WORD_W           = 64;
   localparam int TICKS_PER_SECOND = 1000000000;
   localparam int TICK_W           = $clog2(TICKS_PER_SECOND + 1);
   localparam int PROD_W           = WORD_W + TICK_W;
   localparam int DIV_STEPS        = WORD_W;
   localparam int CNT_W            = $clog2(DIV_STEPS + 1);

   localparam logic [TICK_W-1:0] TICK_BITS = TICK_W'(TICKS_PER_SECOND);

   localparam logic [1:0] REQ_SENT     = 2'd0;
   localparam logic [1:0] REQ_ACKED    = 2'd1;
   localparam logic [1:0] REQ_ACK_DONE = 2'd2;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [WORD_W-1:0] pkt_send_time;
      logic              flight_empty;
      logic [15:0]       pkt_len;
      logic [WORD_W-1:0] ack_time;
      logic [WORD_W-1:0] snap_first_sent_time;
      logic [WORD_W-1:0] snap_delivered_time;
      logic [WORD_W-1:0] snap_delivered;
      logic [WORD_W-1:0] min_rtt;
   } drest_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] out_first_sent_time;
      logic [WORD_W-1:0] out_delivered_time;
      logic [WORD_W-1:0] out_delivered;
      logic              rate_valid;
      logic [WORD_W-1:0] sample_bytes;
      logic [WORD_W-1:0] delivery_rate;
   } drest_rsp_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] bytes;
      logic [WORD_W-1:0] divisor;
   } drest_md_cmd_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] quotient;
   } drest_md_stat_type;

endpackage

@@ hw/rtl/drest_muldiv.sv @@
// bit-serial unit: bytes times ticks per second, then saturating 128/64 division
// depends on drest_pkg
module drest_muldiv
   import drest_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  drest_md_cmd_type  cmd,
   output drest_md_stat_type stat
);

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_MUL  = 3'd1;
   localparam logic [2:0] M_CHK  = 3'd2;
   localparam logic [2:0] M_DIV  = 3'd3;
   localparam logic [2:0] M_FIN  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] mcand_ff, mcand_in;
   logic [WORD_W-1:0] div_ff, div_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] lo_ff, lo_in;

   logic [WORD_W:0]   trial;
   logic [WORD_W:0]   diff;
   logic              qbit;
   logic [WORD_W-1:0] prod_hi;

   assign trial   = {rem_ff, lo_ff[WORD_W-1]};
   assign qbit    = trial >= {1'b0, div_ff};
   assign diff    = trial - {1'b0, div_ff};
   assign prod_hi = WORD_W'(prod_ff[PROD_W-1:WORD_W]);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      div_in   = div_ff;
      tick_in  = tick_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      lo_in    = lo_ff;
      unique case (state_ff)
         M_IDLE: begin
            if (cmd.start) begin
               mcand_in = cmd.bytes;
               div_in   = cmd.divisor;
               prod_in  = '0;
               tick_in  = TICK_BITS;
               cnt_in   = CNT_W'(TICK_W);
               state_in = M_MUL;
            end
         end
         M_MUL: begin
            prod_in = (prod_ff << 1)
                    + (tick_ff[TICK_W-1] ? PROD_W'(mcand_ff) : PROD_W'(0));
            tick_in = tick_ff << 1;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = M_CHK;
            end
         end
         M_CHK: begin
            rem_in = prod_hi;
            lo_in  = prod_ff[WORD_W-1:0];
            if (prod_hi >= div_ff) begin
               lo_in    = '1;
               state_in = M_FIN;
            end else begin
               cnt_in   = CNT_W'(DIV_STEPS);
               state_in = M_DIV;
            end
         end
         M_DIV: begin
            rem_in = qbit ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            lo_in  = {lo_ff[WORD_W-2:0], qbit};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = M_FIN;
            end
         end
         M_FIN: begin
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      mcand_ff <= mcand_in;
      div_ff   <= div_in;
      tick_ff  <= tick_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      lo_ff    <= lo_in;
   end

   assign stat.done     = (state_ff == M_FIN);
   assign stat.quotient = lo_ff;

endmodule

@@ hw/rtl/delivery_rate_estimator.sv @@
// top level of the delivery rate estimator: event decode, estimator state, result register
// depends on drest_pkg and drest_muldiv
//
// usage: one transaction on the req_ channel carries one event (sent, acked,
// ack-done); each event gives exactly one transaction on the rsp_ channel.
// a sent event returns the snapshot to store with the packet, an acked event
// updates the delivered total and the prior sample, an ack-done event may
// return a rate sample in bytes per second.
// sent, acked and unused events and ack-done events without a sample pass their
// result through the result register into the output register, then raise rsp_valid.
// an ack-done event that makes a sample runs the serial multiply-divide unit:
// 30 shift-add steps over the bits of the ticks-per-second constant, one overflow
// check and 64 restoring division steps, the division skipped when the rate
// saturates; then the quotient is taken into the result register and the result
// is loaded into the output register, which raises rsp_valid.
// one event is in work at a time; req_stall is high from the cycle after
// acceptance until the result has moved into the output register.
// the output register holds a result while rsp_stall is high, and the next
// event is accepted meanwhile; its result waits until the register frees.
// reset clears all estimator state to zero and drops rsp_valid.
module delivery_rate_estimator
   import drest_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  drest_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output drest_rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_BUSY = 2'd1;
   localparam logic [1:0] S_HOLD = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [WORD_W-1:0] total_ff, total_in;
   logic [WORD_W-1:0] last_time_ff, last_time_in;
   logic [WORD_W-1:0] first_sent_ff, first_sent_in;
   logic [WORD_W-1:0] prior_del_ff, prior_del_in;
   logic [WORD_W-1:0] prior_time_ff, prior_time_in;
   logic [WORD_W-1:0] send_el_ff, send_el_in;
   logic [WORD_W-1:0] ack_el_ff, ack_el_in;
   drest_rsp_type     res_ff, res_in;
   drest_rsp_type     out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   logic              accept;
   logic              out_free;
   logic [WORD_W-1:0] interval;
   logic [WORD_W-1:0] sample;
   logic              sample_ok;
   drest_md_cmd_type  md_cmd;
   drest_md_stat_type md_stat;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign interval  = (send_el_ff > ack_el_ff) ? send_el_ff : ack_el_ff;
   assign sample    = total_ff - prior_del_ff;
   assign sample_ok = (prior_time_ff != '0) && (interval >= req_data.min_rtt)
                   && (interval != '0);

   assign md_cmd.start   = accept && (req_data.req_type == REQ_ACK_DONE) && sample_ok;
   assign md_cmd.bytes   = sample;
   assign md_cmd.divisor = interval;

   drest_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (md_cmd),
      .stat  (md_stat)
   );

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      last_time_in  = last_time_ff;
      first_sent_in = first_sent_ff;
      prior_del_in  = prior_del_ff;
      prior_time_in = prior_time_ff;
      send_el_in    = send_el_ff;
      ack_el_in     = ack_el_ff;
      res_in        = res_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in   = '0;
               state_in = S_HOLD;
               case (req_data.req_type)
                  REQ_SENT: begin
                     if (req_data.flight_empty) begin
                        first_sent_in = req_data.pkt_send_time;
                        last_time_in  = req_data.pkt_send_time;
                     end
                     res_in.out_first_sent_time = req_data.flight_empty ?
                        req_data.pkt_send_time : first_sent_ff;
                     res_in.out_delivered_time  = req_data.flight_empty ?
                        req_data.pkt_send_time : last_time_ff;
                     res_in.out_delivered       = total_ff;
                  end
                  REQ_ACKED: begin
                     total_in     = total_ff + WORD_W'(req_data.pkt_len);
                     last_time_in = req_data.ack_time;
                     if (req_data.snap_delivered > prior_del_ff) begin
                        prior_del_in  = req_data.snap_delivered;
                        prior_time_in = req_data.snap_delivered_time;
                        send_el_in    = req_data.pkt_send_time
                                      - req_data.snap_first_sent_time;
                        ack_el_in     = req_data.ack_time - req_data.snap_delivered_time;
                        first_sent_in = req_data.pkt_send_time;
                     end
                  end
                  REQ_ACK_DONE: begin
                     if (sample_ok) begin
                        res_in.rate_valid   = 1'b1;
                        res_in.sample_bytes = sample;
                        state_in            = S_BUSY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_BUSY: begin
            if (md_stat.done) begin
               res_in.delivery_rate = md_stat.quotient;
               state_in             = S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         out_valid_ff  <= 1'b0;
         total_ff      <= '0;
         last_time_ff  <= '0;
         first_sent_ff <= '0;
         prior_del_ff  <= '0;
         prior_time_ff <= '0;
         send_el_ff    <= '0;
         ack_el_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         total_ff      <= total_in;
         last_time_ff  <= last_time_in;
         first_sent_ff <= first_sent_in;
         prior_del_ff  <= prior_del_in;
         prior_time_ff <= prior_time_in;
         send_el_ff    <= send_el_in;
         ack_el_ff     <= ack_el_in;
      end
      res_ff <= res_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ hw/rtl/drest_checker.sv @@
// port-level checks for the delivery rate estimator, bound to the top level
// depends on drest_pkg and delivery_rate_estimator_defines.svh
`include "delivery_rate_estimator_defines.svh"

module drest_checker
   import drest_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_stall,
   input drest_req_type req_data,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input drest_rsp_type rsp_data
);

   // stalled result transaction holds
   `DRE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // one event in work at a time
   `DRE_ASSERT_NEXT(a_one_in_work, req_valid && !req_stall, req_stall)

   // no rate fields without a sample
   `DRE_ASSERT_NOW(a_no_rate, rsp_valid && !rsp_data.rate_valid,
      rsp_data.sample_bytes == '0 && rsp_data.delivery_rate == '0)

   // a rate sample carries no snapshot
   `DRE_ASSERT_NOW(a_rate_no_snap, rsp_valid && rsp_data.rate_valid,
      rsp_data.out_first_sent_time == '0 && rsp_data.out_delivered_time == '0
      && rsp_data.out_delivered == '0)

   // reset drops the result
   `DRE_ASSERT_ALWAYS(a_reset_clear, reset, !rsp_valid)

endmodule

bind delivery_rate_estimator drest_checker u_drest_checker (.*);

@@ dv/delivery_rate_estimator_checker.sv @@
// result checker for the delivery rate estimator: tracks the estimator state from
// accepted events and compares every result transaction with its prediction
// depends on drest_pkg
module delivery_rate_estimator_checker
   import drest_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_stall,
   input  drest_req_type req_data,
   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  drest_rsp_type rsp_data,
   output int unsigned   error_count,
   output int unsigned   results_due
);

   logic [WORD_W-1:0] delivered_total;
   logic [WORD_W-1:0] delivered_stamp;
   logic [WORD_W-1:0] first_send_stamp;
   logic [WORD_W-1:0] sample_base_bytes;
   logic [WORD_W-1:0] sample_base_stamp;
   logic [WORD_W-1:0] send_span;
   logic [WORD_W-1:0] ack_span;

   drest_rsp_type expected_event_results[$];
   int unsigned   mismatches = 0;

   function automatic drest_rsp_type predict_event_result(drest_req_type ev);
      drest_rsp_type         res;
      logic [WORD_W-1:0]     span;
      logic [WORD_W-1:0]     bytes;
      logic [2*WORD_W-1:0]   quotient;
      res = '0;
      case (ev.req_type)
         REQ_SENT: begin
            if (ev.flight_empty) begin
               first_send_stamp = ev.pkt_send_time;
               delivered_stamp  = ev.pkt_send_time;
            end
            res.out_first_sent_time = first_send_stamp;
            res.out_delivered_time  = delivered_stamp;
            res.out_delivered       = delivered_total;
         end
         REQ_ACKED: begin
            delivered_total += WORD_W'(ev.pkt_len);
            delivered_stamp  = ev.ack_time;
            if (ev.snap_delivered > sample_base_bytes) begin
               sample_base_bytes = ev.snap_delivered;
               sample_base_stamp = ev.snap_delivered_time;
               send_span         = ev.pkt_send_time - ev.snap_first_sent_time;
               ack_span          = ev.ack_time - ev.snap_delivered_time;
               first_send_stamp  = ev.pkt_send_time;
            end
         end
         REQ_ACK_DONE: begin
            span  = (send_span > ack_span) ? send_span : ack_span;
            bytes = delivered_total - sample_base_bytes;
            if (sample_base_stamp != '0 && span != '0 && span >= ev.min_rtt) begin
               quotient = ({{WORD_W{1'b0}}, bytes} * (2*WORD_W)'(TICKS_PER_SECOND))
                          / {{WORD_W{1'b0}}, span};
               res.rate_valid    = 1'b1;
               res.sample_bytes  = bytes;
               res.delivery_rate = (quotient[2*WORD_W-1:WORD_W] != '0) ? '1
                                                                      : quotient[WORD_W-1:0];
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch_channels
      drest_rsp_type want;
      if (reset) begin
         delivered_total   = '0;
         delivered_stamp   = '0;
         first_send_stamp  = '0;
         sample_base_bytes = '0;
         sample_base_stamp = '0;
         send_span         = '0;
         ack_span          = '0;
         expected_event_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            expected_event_results.push_back(predict_event_result(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_event_results.size() == 0) begin
               $error("result transaction with no event pending");
               mismatches++;
            end else begin
               want = expected_event_results.pop_front();
               check_field("out_first_sent_time", want.out_first_sent_time,
                           rsp_data.out_first_sent_time);
               check_field("out_delivered_time", want.out_delivered_time,
                           rsp_data.out_delivered_time);
               check_field("out_delivered", want.out_delivered, rsp_data.out_delivered);
               check_field("rate_valid", WORD_W'(want.rate_valid),
                           WORD_W'(rsp_data.rate_valid));
               check_field("sample_bytes", want.sample_bytes, rsp_data.sample_bytes);
               check_field("delivery_rate", want.delivery_rate, rsp_data.delivery_rate);
            end
         end
      end
      error_count <= mismatches;
      results_due <= expected_event_results.size();
   end

endmodule

@@ dv/delivery_rate_estimator_tb.sv @@
// top of the delivery rate estimator testbench: clock, reset, event stimulus with
// random idling and result backpressure, and the final verdict
// depends on drest_pkg, delivery_rate_estimator and delivery_rate_estimator_checker
module delivery_rate_estimator_tb;
   import drest_pkg::*;

   localparam logic [1:0]  REQ_UNUSED      = 2'd3;
   localparam int unsigned RANDOM_ITEMS    = 780;
   localparam int unsigned QUIET_AFTER     = 680;
   localparam int unsigned HOLD_OFF_AT     = 300;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned DRAIN_CYCLES    = 120;

   typedef struct packed {
      logic [WORD_W-1:0] send_time;
      logic [WORD_W-1:0] snap_first;
      logic [WORD_W-1:0] snap_time;
      logic [WORD_W-1:0] snap_delivered;
   } inflight_packet_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   drest_req_type req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   drest_rsp_type rsp_data;

   int unsigned         error_count;
   int unsigned         results_due;
   int unsigned         items_issued = 0;
   logic [WORD_W-1:0]   delivered_shadow = '0;
   logic [WORD_W-1:0]   now_ns = 64'd100000;
   inflight_packet_type unacked_packets[$];

   always #2 clock = ~clock;

   delivery_rate_estimator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   delivery_rate_estimator_checker u_scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .error_count (error_count),
      .results_due (results_due)
   );

   function automatic logic [WORD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic drest_req_type random_event();
      drest_req_type ev;
      ev.req_type             = REQ_SENT;
      ev.pkt_send_time        = rand64();
      ev.flight_empty         = 1'($urandom);
      ev.pkt_len              = 16'($urandom);
      ev.ack_time             = rand64();
      ev.snap_first_sent_time = rand64();
      ev.snap_delivered_time  = rand64();
      ev.snap_delivered       = rand64();
      ev.min_rtt              = rand64();
      return ev;
   endfunction

   task automatic issue_event(input drest_req_type ev);
      if (items_issued < QUIET_AFTER && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_issued++;
      if (ev.req_type == REQ_ACKED) begin
         delivered_shadow += WORD_W'(ev.pkt_len);
      end
   endtask

   task automatic acknowledge_oldest();
      inflight_packet_type pkt;
      drest_req_type       ev;
      pkt = unacked_packets.pop_front();
      now_ns += WORD_W'($urandom_range(1, 5000));
      ev = random_event();
      ev.req_type             = REQ_ACKED;
      ev.pkt_send_time        = pkt.send_time;
      ev.ack_time             = now_ns;
      ev.snap_first_sent_time = pkt.snap_first;
      ev.snap_delivered_time  = pkt.snap_time;
      ev.snap_delivered       = pkt.snap_delivered;
      ev.pkt_len = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 1500));
      issue_event(ev);
   endtask

   task automatic finish_ack_processing();
      drest_req_type ev;
      int unsigned   pick;
      ev = random_event();
      ev.req_type = REQ_ACK_DONE;
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
         ev.min_rtt = '0;
      end else if (pick == 7) begin
         ev.min_rtt = rand64();
      end else begin
         ev.min_rtt = WORD_W'($urandom_range(0, 30000));
      end
      issue_event(ev);
   endtask

   task automatic run_flow();
      inflight_packet_type pkt;
      drest_req_type       ev;
      repeat ($urandom_range(1, 6)) begin
         now_ns += WORD_W'($urandom_range(1, 5000));
         pkt.send_time      = now_ns;
         pkt.snap_first     = now_ns - WORD_W'($urandom_range(0, 20000));
         pkt.snap_time      = now_ns - WORD_W'($urandom_range(0, 20000));
         pkt.snap_delivered = delivered_shadow;
         ev = random_event();
         ev.req_type      = REQ_SENT;
         ev.pkt_send_time = now_ns;
         ev.flight_empty  = ($urandom_range(0, 3) == 0);
         issue_event(ev);
         unacked_packets.push_back(pkt);
         if ($urandom_range(0, 2) != 0) begin
            acknowledge_oldest();
            if ($urandom_range(0, 1) != 0) finish_ack_processing();
         end
      end
      while (unacked_packets.size() != 0) acknowledge_oldest();
      finish_ack_processing();
   endtask

   initial begin : result_backpressure
      bit held_off;
      held_off = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (items_issued < QUIET_AFTER) begin
            if (!held_off && items_issued >= HOLD_OFF_AT) begin
               held_off = 1'b1;
               rsp_stall <= 1'b1;
               repeat (HOLD_OFF_CYCLES) @(posedge clock);
               rsp_stall <= 1'b0;
            end else if ($urandom_range(0, 1) != 0) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 17)) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin : stimulus
      drest_req_type ev;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // no prior sample yet
      ev = random_event();
      ev.req_type = REQ_ACK_DONE;
      ev.min_rtt  = '0;
      issue_event(ev);
      ev = random_event();
      ev.flight_empty  = 1'b1;
      ev.pkt_send_time = 64'd1000;
      issue_event(ev);
      ev = random_event();
      ev.flight_empty  = 1'b0;
      ev.pkt_send_time = '1;
      issue_event(ev);
      ev = random_event();
      ev.flight_empty  = 1'b1;
      ev.pkt_send_time = '0;
      issue_event(ev);
      ev = random_event();
      ev.req_type             = REQ_ACKED;
      ev.pkt_len              = '1;
      ev.pkt_send_time        = 64'd3000;
      ev.snap_first_sent_time = 64'd1000;
      ev.snap_delivered_time  = 64'd1000;
      ev.ack_time             = 64'd5000;
      ev.snap_delivered       = 64'd1;
      issue_event(ev);
      // interval equal to, just below and far below min_rtt
      ev = random_event();
      ev.req_type = REQ_ACK_DONE;
      ev.min_rtt  = 64'd4000;
      issue_event(ev);
      ev.min_rtt = 64'd4001;
      issue_event(ev);
      ev.min_rtt = '1;
      issue_event(ev);
      // snapshot not newer than the prior sample
      ev = random_event();
      ev.req_type       = REQ_ACKED;
      ev.snap_delivered = 64'd1;
      ev.pkt_len        = '0;
      issue_event(ev);
      // zero interval
      ev = random_event();
      ev.req_type             = REQ_ACKED;
      ev.snap_delivered       = 64'd2;
      ev.pkt_send_time        = 64'd7;
      ev.snap_first_sent_time = 64'd7;
      ev.snap_delivered_time  = 64'd9;
      ev.ack_time             = 64'd9;
      ev.pkt_len              = 16'd100;
      issue_event(ev);
      ev = random_event();
      ev.req_type = REQ_ACK_DONE;
      ev.min_rtt  = '0;
      issue_event(ev);
      // send elapsed wraps below zero
      ev = random_event();
      ev.req_type             = REQ_ACKED;
      ev.snap_delivered       = 64'd3;
      ev.pkt_send_time        = 64'd5;
      ev.snap_first_sent_time = 64'd10;
      ev.snap_delivered_time  = 64'd20;
      ev.ack_time             = 64'd30;
      ev.pkt_len              = '0;
      issue_event(ev);
      ev = random_event();
      ev.req_type = REQ_ACK_DONE;
      ev.min_rtt  = '1;
      issue_event(ev);
      ev.min_rtt = '0;
      issue_event(ev);
      // unused request code
      ev = random_event();
      ev.req_type = REQ_UNUSED;
      issue_event(ev);
      issue_event('1);
      issue_event('0);
      ev = random_event();
      ev.flight_empty  = 1'b1;
      ev.pkt_send_time = now_ns;
      issue_event(ev);

      while (items_issued < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) != 0) begin
            run_flow();
         end else begin
            repeat ($urandom_range(1, 4)) begin
               ev = random_event();
               ev.req_type = 2'($urandom_range(0, 3));
               if (ev.req_type == REQ_ACKED) begin
                  ev.snap_delivered = rand64() % (delivered_shadow + 64'd1);
               end
               issue_event(ev);
            end
         end
      end

      // rate overflow: snapshot far above the delivered total
      ev = random_event();
      ev.req_type             = REQ_ACKED;
      ev.snap_delivered       = 64'h8000_0000_0000_0000;
      ev.snap_first_sent_time = 64'd40;
      ev.pkt_send_time        = 64'd41;
      ev.snap_delivered_time  = 64'd50;
      ev.ack_time             = 64'd51;
      ev.pkt_len              = 16'd1;
      issue_event(ev);
      ev = random_event();
      ev.req_type = REQ_ACK_DONE;
      ev.min_rtt  = 64'd1;
      issue_event(ev);
      // largest snapshot, sample bytes wrap
      ev = random_event();
      ev.req_type             = REQ_ACKED;
      ev.snap_delivered       = '1;
      ev.snap_first_sent_time = '1;
      ev.pkt_send_time        = '1;
      ev.snap_delivered_time  = '1 - 64'd2;
      ev.ack_time             = '1;
      ev.pkt_len              = '1;
      issue_event(ev);
      ev = random_event();
      ev.req_type = REQ_ACK_DONE;
      ev.min_rtt  = 64'd2;
      issue_event(ev);
      ev = random_event();
      ev.flight_empty = 1'b0;
      issue_event(ev);

      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : run_limit
      #3000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
